// File: hdl/sem_pkg.sv
`default_nettype none

package sem_pkg;

    // pixel layout
    localparam int CHANNELS = 3;
    localparam int CHAN_W   = 8;
    localparam int PIX_W    = CHANNELS * CHAN_W;

    // configuration registers
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 12;
    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W  = 2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam int MIN_DIM      = 3;
    localparam int RESET_WIDTH  = 640;
    localparam int RESET_HEIGHT = 480;

    // magnitude datapath
    localparam int GRAD_W      = 11;   // +-1020 fits
    localparam int SUM_W       = 21;   // gx^2 + gy^2 < 2^21
    localparam int ROOT_W      = 8;
    localparam int ROOT_STEP_W = 3;

    // job queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    // 3x3 window taps, column-major: left, center, right columns
    localparam int WIN_TL   = 0;
    localparam int WIN_ML   = 1;
    localparam int WIN_BL   = 2;
    localparam int WIN_TC   = 3;
    localparam int WIN_MC   = 4;
    localparam int WIN_BC   = 5;
    localparam int WIN_TR   = 6;
    localparam int WIN_MR   = 7;
    localparam int WIN_BR   = 8;
    localparam int WIN_TAPS = 9;

    typedef logic [PIX_W-1:0] t_pix;

    typedef struct packed {
        t_pix [WIN_TAPS-1:0] win;
        logic                last;
    } t_job;

endpackage

`default_nettype wire

// File: hdl/sobel_edge_magnitude_rgb.sv
`default_nettype none

// Sobel 3x3 gradient magnitude on a raster RGB stream. Pixels enter one per request
// in raster order; each request yields at most one result, the magnitude
// min(255, floor(sqrt(gx^2 + gy^2))) per channel at the pixel one row up and one
// column left of the pixel just taken, and only for interior pixels (rows 1..H-2,
// columns 1..W-2). frame_last marks the final interior pixel of a frame. Geometry
// is set through the configuration channel (index 0 width, 3..MAX_WIDTH, taken from
// the low 11 data bits; index 1 height, 3..4095; out of range values saturate) and
// any such write restarts the frame; write only while the block is idle. The line
// store is not cleared at reset: its contents are meaningless until the first two
// rows of a frame have passed, which never matters with a steady geometry. Timing:
// the input side takes one pixel per cycle as long as the four-entry job queue has
// room. The magnitude engine works on one interior pixel at a time: queue pop,
// gradient, squares, eight square-root bit steps, result hand off, holding there
// through any output stall. It takes no new job until the result is taken, so it
// sets the sustained rate for interior pixels.

module sobel_edge_magnitude_rgb
    import sem_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
)
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // configuration write channel
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    // pixel input
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [CHAN_W-1:0]     i_chan_blue,
    input  wire logic [CHAN_W-1:0]     i_chan_green,
    input  wire logic [CHAN_W-1:0]     i_chan_red,
    // result output
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [CHAN_W-1:0]          o_edge_blue,
    output logic [CHAN_W-1:0]          o_edge_green,
    output logic [CHAN_W-1:0]          o_edge_red,
    output logic                       o_frame_last
);

    t_pix            w_pixel;
    t_pix            w_edge;
    t_job            w_push_job;
    t_job            w_pop_job;
    logic            w_push;
    logic            w_pop;
    logic            w_empty;
    logic            w_full;
    logic            w_room;
    logic [QPTR_W:0] w_count;

    // blue in the low byte, as the pixel bytes arrive
    assign w_pixel = {i_chan_red, i_chan_green, i_chan_blue};

    // two slots free: one for the job already in the front stage, one for the next
    assign w_room = (w_count <= (QPTR_W+1)'(QUEUE_DEPTH - 2));

    // front: counters, line store, window, interior classification
    sem_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_pixel     (w_pixel),
        .i_room      (w_room),
        .o_push      (w_push),
        .o_job       (w_push_job)
    );

    // window jobs waiting for the magnitude engine
    sem_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_job),
        .i_pop   (w_pop),
        .o_data  (w_pop_job),
        .o_empty (w_empty),
        .o_full  (w_full),
        .o_count (w_count)
    );

    // back: gradients, squares, bit-serial square root, output register
    sem_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (w_pop_job),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_edge  (w_edge),
        .o_last  (o_frame_last)
    );

    assign o_edge_blue  = w_edge[0*CHAN_W +: CHAN_W];
    assign o_edge_green = w_edge[1*CHAN_W +: CHAN_W];
    assign o_edge_red   = w_edge[2*CHAN_W +: CHAN_W];

    // a window job must never be dropped at a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_full))
        else $error("job pushed into a full queue");

    // engine only pops real jobs
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_pop && w_empty))
        else $error("job popped from an empty queue");

    // one result per job: after hand off the output drops until the next job finishes
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready) |=> !o_valid)
        else $error("result repeated after hand off");

    // input side throttles before the queue can fill
    a_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> (w_count < (QPTR_W+1)'(QUEUE_DEPTH)))
        else $error("input ready with a full queue");

endmodule

`default_nettype wire

// File: hdl/sem_queue.sv
`default_nettype none

module sem_queue
    import sem_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire t_job              i_data,
    input  wire logic              i_pop,
    output t_job                   o_data,
    output logic                   o_empty,
    output logic                   o_full,
    output logic [QPTR_W:0]        o_count
);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QPTR_W:0]   r_count;

    logic do_push;
    logic do_pop;

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_count = r_count;

endmodule

`default_nettype wire

// File: hdl/sem_front.sv
`default_nettype none

module sem_front
    import sem_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
)
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire t_pix                  i_pixel,
    input  wire logic                  i_room,
    output logic                       o_push,
    output t_job                       o_job
);

    localparam int AW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CMPW = ((AW > WIDTH_W) ? AW : WIDTH_W) + 1;
    localparam int RST_W = (RESET_WIDTH < MAX_WIDTH) ? RESET_WIDTH : MAX_WIDTH;

    // line store: high half = two rows up, low half = previous row
    logic [2*PIX_W-1:0] r_line [MAX_WIDTH];
    logic [2*PIX_W-1:0] r_rd;

    logic [WIDTH_W-1:0]  r_width;
    logic [HEIGHT_W-1:0] r_height;
    logic [AW-1:0]       r_col;
    logic [HEIGHT_W-1:0] r_row;

    logic                r_s1_valid;
    logic [AW-1:0]       r_s1_col;
    t_pix                r_s1_px;
    logic                r_s1_inter;
    logic                r_s1_last;

    t_pix                r_win [6];

    logic                accept;
    logic                cfg_wr;
    logic [WIDTH_W-1:0]  n_width;
    logic [HEIGHT_W-1:0] n_height;
    logic                col_wrap;
    logic                row_wrap;
    logic                is_inter;
    logic                is_last;
    t_pix                cur_top;
    t_pix                cur_mid;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = i_room;
    assign accept      = i_valid && o_ready;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    // saturate geometry writes
    always_comb begin
        n_width  = i_cfg_data[WIDTH_W-1:0];
        n_height = i_cfg_data[HEIGHT_W-1:0];
        if (n_width < WIDTH_W'(MIN_DIM)) begin
            n_width = WIDTH_W'(MIN_DIM);
        end else if (32'(n_width) > MAX_WIDTH) begin
            n_width = WIDTH_W'(MAX_WIDTH);
        end
        if (n_height < HEIGHT_W'(MIN_DIM)) begin
            n_height = HEIGHT_W'(MIN_DIM);
        end
    end

    assign col_wrap = (CMPW'(r_col) + 1'b1) >= CMPW'(r_width);
    assign row_wrap = ((HEIGHT_W+1)'(r_row) + 1'b1) >= (HEIGHT_W+1)'(r_height);
    assign is_inter = (r_row >= HEIGHT_W'(2)) && (r_col >= AW'(2));
    assign is_last  = ((HEIGHT_W+1)'(r_row) + 1'b1 == (HEIGHT_W+1)'(r_height))
                   && (CMPW'(r_col) + 1'b1 == CMPW'(r_width));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= WIDTH_W'(RST_W);
            r_height   <= HEIGHT_W'(RESET_HEIGHT);
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
            if (cfg_wr && (i_cfg_index == REG_IMAGE_WIDTH
                           || i_cfg_index == REG_IMAGE_HEIGHT)) begin
                if (i_cfg_index == REG_IMAGE_WIDTH) begin
                    r_width <= n_width;
                end else begin
                    r_height <= n_height;
                end
                r_col <= '0;
                r_row <= '0;
            end else if (accept) begin
                if (col_wrap) begin
                    r_col <= '0;
                    r_row <= row_wrap ? '0 : r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
        end
    end

    // stage 1 payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_col   <= r_col;
            r_s1_px    <= i_pixel;
            r_s1_inter <= is_inter;
            r_s1_last  <= is_last;
        end
    end

    // read at accept, write back in the cycle after (never the same column)
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd <= r_line[r_col];
        end
        if (r_s1_valid) begin
            r_line[r_s1_col] <= {cur_mid, r_s1_px};
        end
    end

    assign cur_top = r_rd[2*PIX_W-1:PIX_W];
    assign cur_mid = r_rd[PIX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else if (r_s1_valid) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= cur_top;
            r_win[4] <= cur_mid;
            r_win[5] <= r_s1_px;
        end
    end

    assign o_push = r_s1_valid && r_s1_inter;

    always_comb begin
        o_job.win[WIN_TL] = r_win[0];
        o_job.win[WIN_ML] = r_win[1];
        o_job.win[WIN_BL] = r_win[2];
        o_job.win[WIN_TC] = r_win[3];
        o_job.win[WIN_MC] = r_win[4];
        o_job.win[WIN_BC] = r_win[5];
        o_job.win[WIN_TR] = cur_top;
        o_job.win[WIN_MR] = cur_mid;
        o_job.win[WIN_BR] = r_s1_px;
        o_job.last        = r_s1_last;
    end

endmodule

`default_nettype wire

// File: hdl/sem_back.sv
`default_nettype none

module sem_back
    import sem_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_job i_job,
    input  wire logic i_empty,
    output logic      o_pop,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_pix      o_edge,
    output logic      o_last
);

    typedef enum logic [2:0] {S_IDLE, S_GRAD, S_SQR, S_ROOT, S_OUT} t_state;

    t_state                    r_state;
    t_job                      r_job;
    logic signed [GRAD_W-1:0]  r_gx   [CHANNELS];
    logic signed [GRAD_W-1:0]  r_gy   [CHANNELS];
    logic [SUM_W-1:0]          r_sum  [CHANNELS];
    logic [ROOT_W-1:0]         r_root [CHANNELS];
    logic [ROOT_STEP_W-1:0]    r_step;
    logic                      r_valid;
    t_pix                      r_edge;
    logic                      r_last;

    logic signed [GRAD_W-1:0]   n_gx   [CHANNELS];
    logic signed [GRAD_W-1:0]   n_gy   [CHANNELS];
    logic [SUM_W-1:0]           n_sum  [CHANNELS];
    logic [ROOT_W-1:0]          n_root [CHANNELS];

    function automatic logic signed [GRAD_W-1:0] tap(t_job j, int k, int c);
        return $signed({(GRAD_W-CHAN_W)'(0), j.win[k][c*CHAN_W +: CHAN_W]});
    endfunction

    assign o_pop = (r_state == S_IDLE) && !i_empty;

    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            n_gx[c] = (tap(r_job, WIN_TR, c) + (tap(r_job, WIN_MR, c) <<< 1)
                       + tap(r_job, WIN_BR, c))
                    - (tap(r_job, WIN_TL, c) + (tap(r_job, WIN_ML, c) <<< 1)
                       + tap(r_job, WIN_BL, c));
            n_gy[c] = (tap(r_job, WIN_BL, c) + (tap(r_job, WIN_BC, c) <<< 1)
                       + tap(r_job, WIN_BR, c))
                    - (tap(r_job, WIN_TL, c) + (tap(r_job, WIN_TC, c) <<< 1)
                       + tap(r_job, WIN_TR, c));
        end
    end

    always_comb begin
        logic signed [2*GRAD_W-1:0] sx;
        logic signed [2*GRAD_W-1:0] sy;
        for (int c = 0; c < CHANNELS; c++) begin
            sx = r_gx[c] * r_gx[c];
            sy = r_gy[c] * r_gy[c];
            n_sum[c] = sx[SUM_W-1:0] + sy[SUM_W-1:0];
        end
    end

    // one root bit per cycle; sums above 255^2 settle at 255 by themselves
    always_comb begin
        logic [ROOT_W-1:0]   t;
        logic [2*ROOT_W-1:0] tt;
        for (int c = 0; c < CHANNELS; c++) begin
            t  = r_root[c] | (ROOT_W'(1) << r_step);
            tt = t * t;
            n_root[c] = (SUM_W'(tt) <= r_sum[c]) ? t : r_root[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_step  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_job   <= i_job;
                        r_state <= S_GRAD;
                    end
                end
                S_GRAD: begin
                    for (int c = 0; c < CHANNELS; c++) begin
                        r_gx[c] <= n_gx[c];
                        r_gy[c] <= n_gy[c];
                    end
                    r_state <= S_SQR;
                end
                S_SQR: begin
                    for (int c = 0; c < CHANNELS; c++) begin
                        r_sum[c]  <= n_sum[c];
                        r_root[c] <= '0;
                    end
                    r_step  <= ROOT_STEP_W'(ROOT_W - 1);
                    r_state <= S_ROOT;
                end
                S_ROOT: begin
                    for (int c = 0; c < CHANNELS; c++) begin
                        r_root[c] <= n_root[c];
                    end
                    r_step <= r_step - 1'b1;
                    if (r_step == '0) begin
                        for (int c = 0; c < CHANNELS; c++) begin
                            r_edge[c*CHAN_W +: CHAN_W] <= n_root[c];
                        end
                        r_last  <= r_job.last;
                        r_valid <= 1'b1;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_valid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid = r_valid;
    assign o_edge  = r_edge;
    assign o_last  = r_last;

endmodule

`default_nettype wire

// File: bench/sobel_edge_magnitude_rgb_test.sv
`timescale 1ns / 100ps

// Pixel-stream bench for the Sobel magnitude block: a clocked driver feeds pixel and
// geometry requests from a queue, a clocked monitor takes edge results and
// compares them with those worked out by an in-bench predictor.
module sobel_edge_magnitude_rgb_test;
    import sem_pkg::*;

    localparam int MAX_W        = 1024;
    localparam int MAX_H        = 4095;
    localparam int EDGE_CLAMP   = 255;
    localparam int SETTLE_CYC   = 32;     // quiet cycles before a geometry write
    localparam int QUIET_TAIL   = 150;    // last requests go without idling
    localparam int STALL_LIMIT  = 2000;   // cycles with no handshake at all
    localparam int DRAIN_CYC    = 64;
    localparam int RANDOM_ITEMS = 1060;
    localparam int RANDOM_SLACK = 100;    // random frames may run this far past the budget
    localparam int MAX_REPORTS  = 10;

    // indexes outside the register map; a write there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_3 = 2'd3;

    typedef enum logic {KIND_PIXEL, KIND_CFG} t_kind;
    typedef enum logic [1:0] {STYLE_NOISE, STYLE_BINARY, STYLE_SMOOTH} t_style;

    typedef struct packed {
        t_kind                 kind;
        t_pix                  pix;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_request;

    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
        logic              last;
    } t_edge;

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  pix_valid = 1'b0;
    logic                  pix_ready;
    logic [CHAN_W-1:0]     pix_blue  = '0;
    logic [CHAN_W-1:0]     pix_green = '0;
    logic [CHAN_W-1:0]     pix_red   = '0;
    logic                  res_valid;
    logic                  res_ready = 1'b0;
    logic [CHAN_W-1:0]     edge_blue;
    logic [CHAN_W-1:0]     edge_green;
    logic [CHAN_W-1:0]     edge_red;
    logic                  frame_last;

    sobel_edge_magnitude_rgb #(
        .MAX_WIDTH (MAX_W)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_valid      (pix_valid),
        .o_ready      (pix_ready),
        .i_chan_blue  (pix_blue),
        .i_chan_green (pix_green),
        .i_chan_red   (pix_red),
        .o_valid      (res_valid),
        .i_ready      (res_ready),
        .o_edge_blue  (edge_blue),
        .o_edge_green (edge_green),
        .o_edge_red   (edge_red),
        .o_frame_last (frame_last)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------------------
    // Predictor state: two row buffers (previous row low half, the one before it
    // high half), the two previous window columns, raster position and geometry.
    // ---------------------------------------------------------------------------
    t_pix        row_store [2*MAX_W];
    t_pix        win_col   [6];
    int unsigned cur_col;
    int unsigned cur_row;
    int unsigned geo_width;
    int unsigned geo_height;
    t_edge       pending_edges [$];

    t_request    stream_q [$];
    int          walk [3];
    int unsigned error_cnt = 0;

    function automatic int unsigned dim_clamp(int unsigned v, int unsigned hi);
        if (v < MIN_DIM)
            return MIN_DIM;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // floor(sqrt(sum)), held at 255 once the root would pass it
    function automatic int unsigned edge_root(int unsigned sum);
        int unsigned root;
        int unsigned trial;
        if (sum >= (EDGE_CLAMP + 1) * (EDGE_CLAMP + 1))
            return EDGE_CLAMP;
        root = 0;
        for (int b = ROOT_W - 1; b >= 0; b--) begin
            trial = root | (1 << b);
            if (trial * trial <= sum)
                root = trial;
        end
        return root;
    endfunction

    function automatic int unsigned pick_idle_rate();
        case ($urandom_range(3))
            0:       return 0;
            1:       return 5;
            2:       return 20;
            default: return 50;
        endcase
    endfunction

    task automatic clear_predictor();
        foreach (row_store[i])
            row_store[i] = '0;
        foreach (win_col[i])
            win_col[i] = '0;
        cur_col    = 0;
        cur_row    = 0;
        geo_width  = RESET_WIDTH;
        geo_height = RESET_HEIGHT;
        pending_edges.delete();
    endtask

    // geometry write: saturate, then restart the frame (buffers are kept)
    task automatic apply_geometry(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        if (idx == REG_IMAGE_WIDTH) begin
            geo_width = dim_clamp(val[WIDTH_W-1:0], MAX_W);
        end else if (idx == REG_IMAGE_HEIGHT) begin
            geo_height = dim_clamp(val[HEIGHT_W-1:0], MAX_H);
        end else begin
            return;
        end
        cur_col = 0;
        cur_row = 0;
    endtask

    // one pixel in: rotate the row buffers, score the window centre if interior
    task automatic predict_edge(t_pix px);
        t_pix        up2;
        t_pix        up1;
        int          tl, ml, bl, tc, bc, tr, mr, br;
        int          gx, gy;
        int unsigned mag [CHANNELS];
        t_edge       e;
        up2 = row_store[MAX_W + cur_col];
        up1 = row_store[cur_col];
        row_store[MAX_W + cur_col] = up1;
        row_store[cur_col]         = px;
        if (cur_row >= 2 && cur_col >= 2) begin
            for (int c = 0; c < CHANNELS; c++) begin
                tl = win_col[0][c*CHAN_W +: CHAN_W];
                ml = win_col[1][c*CHAN_W +: CHAN_W];
                bl = win_col[2][c*CHAN_W +: CHAN_W];
                tc = win_col[3][c*CHAN_W +: CHAN_W];
                bc = win_col[5][c*CHAN_W +: CHAN_W];
                tr = up2[c*CHAN_W +: CHAN_W];
                mr = up1[c*CHAN_W +: CHAN_W];
                br = px[c*CHAN_W +: CHAN_W];
                gx = (tr + 2 * mr + br) - (tl + 2 * ml + bl);
                gy = (bl + 2 * bc + br) - (tl + 2 * tc + tr);
                mag[c] = edge_root(gx * gx + gy * gy);
            end
            e.blue  = CHAN_W'(mag[0]);
            e.green = CHAN_W'(mag[1]);
            e.red   = CHAN_W'(mag[2]);
            e.last  = (cur_row == geo_height - 1) && (cur_col == geo_width - 1);
            pending_edges.push_back(e);
        end
        win_col[0] = win_col[3];
        win_col[1] = win_col[4];
        win_col[2] = win_col[5];
        win_col[3] = up2;
        win_col[4] = up1;
        win_col[5] = px;
        cur_col++;
        if (cur_col >= geo_width) begin
            cur_col = 0;
            cur_row++;
            if (cur_row >= geo_height)
                cur_row = 0;
        end
    endtask

    // ---------------------------------------------------------------------------
    // Driver. Pixel requests go out with random idle bursts; a geometry request
    // waits until no edge is outstanding and the pipe has been quiet for a while.
    // Prediction runs here, at the edge where a request is taken.
    // ---------------------------------------------------------------------------
    int unsigned gap_left     = 0;
    int unsigned settle_cnt   = 0;
    int unsigned drv_idle_pct = 0;
    int unsigned pix_taken    = 0;
    logic        pix_hold;
    logic        cfg_hold;
    t_request    req;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix_valid  <= 1'b0;
            cfg_valid  <= 1'b0;
            gap_left   = 0;
            settle_cnt = 0;
            clear_predictor();
        end else begin
            pix_hold = pix_valid && !pix_ready;
            cfg_hold = cfg_valid && !cfg_ready;
            if (pix_valid && pix_ready) begin
                predict_edge({pix_red, pix_green, pix_blue});
                settle_cnt = 0;
                pix_taken++;
                if (pix_taken % 256 == 0)
                    drv_idle_pct = pick_idle_rate();
            end
            if (cfg_valid && cfg_ready)
                apply_geometry(cfg_index, cfg_data);

            if (!pix_hold && !cfg_hold) begin
                if (pending_edges.size() == 0) begin
                    if (settle_cnt < SETTLE_CYC)
                        settle_cnt++;
                end else begin
                    settle_cnt = 0;
                end
                if (gap_left != 0) begin
                    gap_left--;
                end else if (stream_q.size() != 0) begin
                    if (stream_q[0].kind == KIND_CFG) begin
                        if (settle_cnt >= SETTLE_CYC) begin
                            req        = stream_q.pop_front();
                            cfg_index <= req.index;
                            cfg_data  <= req.data;
                            cfg_hold   = 1'b1;
                            settle_cnt = 0;
                        end
                    end else if (stream_q.size() > QUIET_TAIL &&
                                 $urandom_range(99) < drv_idle_pct) begin
                        gap_left = $urandom_range(1, 15) - 1;
                    end else begin
                        req        = stream_q.pop_front();
                        pix_blue  <= req.pix[0*CHAN_W +: CHAN_W];
                        pix_green <= req.pix[1*CHAN_W +: CHAN_W];
                        pix_red   <= req.pix[2*CHAN_W +: CHAN_W];
                        pix_hold   = 1'b1;
                    end
                end
            end
            pix_valid <= pix_hold;
            cfg_valid <= cfg_hold;
        end
    end

    // ---------------------------------------------------------------------------
    // Monitor: random back-pressure bursts, every taken edge checked in order.
    // ---------------------------------------------------------------------------
    int unsigned stall_left   = 0;
    int unsigned mon_idle_pct = 0;
    int unsigned edges_taken  = 0;
    t_edge       got;
    t_edge       want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (res_valid && res_ready) begin
                got = {edge_blue, edge_green, edge_red, frame_last};
                edges_taken++;
                if (edges_taken % 128 == 0)
                    mon_idle_pct = pick_idle_rate() / 4;
                if (pending_edges.size() == 0) begin
                    error_cnt++;
                    if (error_cnt <= MAX_REPORTS)
                        $display("%0t: unexpected edge b=%0d g=%0d r=%0d last=%0b",
                                 $realtime, got.blue, got.green, got.red, got.last);
                end else begin
                    want = pending_edges.pop_front();
                    if (got !== want) begin
                        error_cnt++;
                        if (error_cnt <= MAX_REPORTS) begin
                            $write("%0t: edge mismatch, expected b=%0d g=%0d r=%0d last=%0b",
                                   $realtime, want.blue, want.green, want.red, want.last);
                            $display(", got b=%0d g=%0d r=%0d last=%0b",
                                     got.blue, got.green, got.red, got.last);
                        end
                    end
                end
            end
            if (stall_left != 0) begin
                stall_left--;
                res_ready <= 1'b0;
            end else if (stream_q.size() > QUIET_TAIL &&
                         $urandom_range(99) < mon_idle_pct) begin
                stall_left = $urandom_range(1, 15) - 1;
                res_ready <= 1'b0;
            end else begin
                res_ready <= 1'b1;
            end
        end
    end

    // watchdog: any handshake on any channel counts as progress
    int unsigned quiet_cnt = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (pix_valid && pix_ready) || (cfg_valid && cfg_ready) ||
            (res_valid && res_ready)) begin
            quiet_cnt <= 0;
        end else if (quiet_cnt >= STALL_LIMIT) begin
            $display("sobel_edge_magnitude_rgb_test failed");
            $finish;
        end else begin
            quiet_cnt <= quiet_cnt + 1;
        end
    end

    // ---------------------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------------------
    task automatic push_pixel(t_pix px);
        t_request item;
        item.kind  = KIND_PIXEL;
        item.pix   = px;
        item.index = '0;
        item.data  = '0;
        stream_q.push_back(item);
    endtask

    task automatic push_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        t_request item;
        item.kind  = KIND_CFG;
        item.pix   = '0;
        item.index = idx;
        item.data  = val;
        stream_q.push_back(item);
    endtask

    // noise saturates most edges, binary gives hard 0/255 steps,
    // smooth is a random walk that keeps magnitudes in the unclamped range
    task automatic push_run(int unsigned count, t_style style);
        t_pix px;
        for (int unsigned i = 0; i < count; i++) begin
            for (int c = 0; c < CHANNELS; c++) begin
                case (style)
                    STYLE_NOISE:  px[c*CHAN_W +: CHAN_W] = CHAN_W'($urandom_range(255));
                    STYLE_BINARY: px[c*CHAN_W +: CHAN_W] = $urandom_range(1) ? 8'hFF : 8'h00;
                    default: begin
                        walk[c] = walk[c] + int'($urandom_range(8)) - 4;
                        if (walk[c] < 0)
                            walk[c] = 0;
                        if (walk[c] > 255)
                            walk[c] = 255;
                        px[c*CHAN_W +: CHAN_W] = CHAN_W'(walk[c]);
                    end
                endcase
            end
            push_pixel(px);
        end
    endtask

    initial begin
        int unsigned stim_w;
        int unsigned stim_h;
        int unsigned area;
        int unsigned count;
        int unsigned rand_items;
        int unsigned pick;
        int unsigned which;
        logic [CFG_DATA_W-1:0] w_data;
        logic [CFG_DATA_W-1:0] h_data;

        for (int c = 0; c < CHANNELS; c++)
            walk[c] = $urandom_range(255);

        // reset geometry (640 wide): start of row 0 is all border, nothing comes out
        push_run(16, STYLE_NOISE);

        // width with bit 11 set is masked to 2, then saturates to 3; height 0 -> 3
        push_cfg(REG_IMAGE_WIDTH, 12'h802);
        push_cfg(REG_IMAGE_HEIGHT, 12'h000);

        // 3x3 frame with full-scale steps: blue vertical edge, green horizontal
        // edge, both clamp to 255; red flat gives zero
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                push_pixel({8'h00, (r == 2) ? 8'hFF : 8'h00, (c == 2) ? 8'hFF : 8'h00});

        // next frame straight after the wrap: flat blue, small ramp on green,
        // red slopes that need the floor of a non-square sum; unmapped index
        // written mid frame must neither restart nor change the geometry
        for (int i = 0; i < 9; i++) begin
            if (i == 4)
                push_cfg(REG_UNMAPPED_2, 12'hFFF);
            push_pixel({8'(10 * (i % 3) + 7 * (i / 3)), 8'(i % 3 + i / 3), 8'hFF});
        end
        push_cfg(REG_UNMAPPED_3, 12'h000);

        // partial frame, cut off by the next geometry write
        push_run(4, STYLE_BINARY);

        // widest line (0xFFF masked and saturated to 1024), shortest frame;
        // only the start of row 0, cut off by the next geometry write
        push_cfg(REG_IMAGE_WIDTH, 12'hFFF);
        push_cfg(REG_IMAGE_HEIGHT, 12'd3);
        push_run(16, STYLE_SMOOTH);

        // tallest frame at the narrowest width, run only partway down
        push_cfg(REG_IMAGE_WIDTH, 12'd3);
        push_cfg(REG_IMAGE_HEIGHT, 12'hFFF);
        push_run(3 * 60, STYLE_NOISE);
        stim_w = 3;
        stim_h = MAX_H;

        // random geometries, whole frames with the odd truncated one
        rand_items = 0;
        while (rand_items < RANDOM_ITEMS) begin
            pick   = $urandom_range(99);
            w_data = (pick < 5) ? CFG_DATA_W'($urandom_range(2)) :
                     (pick < 75) ? CFG_DATA_W'($urandom_range(3, 8)) :
                                   CFG_DATA_W'($urandom_range(9, 40));
            pick   = $urandom_range(99);
            h_data = (pick < 5) ? CFG_DATA_W'($urandom_range(2)) :
                     (pick < 80) ? CFG_DATA_W'($urandom_range(3, 6)) :
                                   CFG_DATA_W'($urandom_range(7, 16));
            which  = (stim_h > 16) ? 0 : $urandom_range(2);
            if (which != 2) begin
                push_cfg(REG_IMAGE_WIDTH, w_data);
                stim_w = dim_clamp(w_data, MAX_W);
            end
            if (which != 1) begin
                push_cfg(REG_IMAGE_HEIGHT, h_data);
                stim_h = dim_clamp(h_data, MAX_H);
            end
            area  = stim_w * stim_h;
            count = $urandom_range(1, 3) * area;
            if ($urandom_range(3) == 0)
                count += $urandom_range(1, area - 1);
            if (rand_items + count > RANDOM_ITEMS + RANDOM_SLACK)
                count = RANDOM_ITEMS + RANDOM_SLACK - rand_items;
            push_run(count, t_style'($urandom_range(2)));
            rand_items += count;
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (stream_q.size() != 0 || pix_valid || cfg_valid || pending_edges.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);

        if (error_cnt == 0 && pending_edges.size() == 0) begin
            $display("sobel_edge_magnitude_rgb_test passed");
        end else begin
            $display("sobel_edge_magnitude_rgb_test failed");
        end
        $finish;
    end

endmodule
